>>> src/temporal_infection_spread_core_assert.svh
// assertion macros for the infection spread core checker
`ifndef TEMPORAL_INFECTION_SPREAD_CORE_ASSERT_SVH
`define TEMPORAL_INFECTION_SPREAD_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TIS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("infection spread core check failed");

// consequent checked in the cycle after the antecedent
`define TIS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("infection spread core check failed");

`endif

>>> src/tis_pkg.sv
// shared types and constants for the infection spread core
`timescale 1ns / 1ps

package tis_pkg;

   localparam int NODE_W     = 10;
   localparam int FIELD_DAY_W = 16;
   localparam int PERIOD_W   = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // register word indexes (byte address / 4)
   localparam logic [1:0] REG_INDEX_NODE = 2'd0;
   localparam logic [1:0] REG_INDEX_DAY  = 2'd1;
   localparam logic [1:0] REG_PERIOD     = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0]      index_node;
      logic [FIELD_DAY_W-1:0] index_day;
      logic [PERIOD_W-1:0]    period;
   } tis_cfg_type;

   typedef struct packed {
      logic capture;     // latch edge fields, read source entry
      logic clear;       // sweep write of the node table
      logic mark_run;    // sweep belongs to a run start, mark the index node
      logic fetch;       // read target entry
      logic eval;        // decide, write target, emit result
      logic start_done;  // emit the start result
   } tis_cmd_type;

   typedef struct packed {
      logic clr_last;
   } tis_stat_type;

endpackage

>>> src/tis_csr.sv
// configuration register file on the apb-style port
`timescale 1ns / 1ps

module tis_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tis_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [tis_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [tis_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output tis_pkg::tis_cfg_type                cfg
);

   tis_pkg::tis_cfg_type cfg_ff;
   logic [1:0]           reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.index_node <= '0;
         cfg_ff.index_day  <= '0;
         cfg_ff.period     <= tis_pkg::PERIOD_W'(1);
      end else if (wr_en) begin
         case (reg_idx)
            tis_pkg::REG_INDEX_NODE: cfg_ff.index_node <= pwdata[tis_pkg::NODE_W-1:0];
            tis_pkg::REG_INDEX_DAY:  cfg_ff.index_day  <= pwdata[tis_pkg::FIELD_DAY_W-1:0];
            tis_pkg::REG_PERIOD:     cfg_ff.period     <= pwdata[tis_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         tis_pkg::REG_INDEX_NODE: prdata = tis_pkg::CSR_DATA_W'(cfg_ff.index_node);
         tis_pkg::REG_INDEX_DAY:  prdata = tis_pkg::CSR_DATA_W'(cfg_ff.index_day);
         tis_pkg::REG_PERIOD:     prdata = tis_pkg::CSR_DATA_W'(cfg_ff.period);
         default:                 prdata = '0;
      endcase
   end

endmodule

>>> src/tis_ctrl.sv
// controller state machine: table sweep, edge fetch and evaluate sequence
`timescale 1ns / 1ps

module tis_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_func,
   input  tis_pkg::tis_stat_type stat,
   output logic                  busy,
   output tis_pkg::tis_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_EVAL
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      run_ff;
   logic      accept;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.mark_run   = run_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in       = S_IDLE;
               cmd.start_done = run_ff;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_func) begin
                  state_in = S_CLEAR;
               end else begin
                  state_in    = S_FETCH;
                  cmd.capture = 1'b1;
               end
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // the sweep after reset only clears; later sweeps also mark the index node
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
         run_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
         if (accept && req_func) begin
            run_ff <= 1'b1;
         end
      end
   end

endmodule

>>> src/tis_dp.sv
// datapath: node table, window compare and result register
`timescale 1ns / 1ps

module tis_dp #(
   parameter int NODE_COUNT = 1024,
   parameter int DAY_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tis_pkg::tis_cmd_type               cmd,
   input  tis_pkg::tis_cfg_type               cfg,
   input  logic [tis_pkg::FIELD_DAY_W-1:0]    req_edge_day,
   input  logic [tis_pkg::NODE_W-1:0]         req_source_node,
   input  logic [tis_pkg::NODE_W-1:0]         req_target_node,
   output tis_pkg::tis_stat_type              stat,
   output logic                               rsp_valid,
   output logic                               rsp_newly_infected,
   output logic [tis_pkg::NODE_W-1:0]         rsp_infected_node,
   output logic                               rsp_out_of_order
);

   localparam int AW = $clog2(NODE_COUNT);
   localparam int CW = (DAY_BITS > tis_pkg::PERIOD_W) ? DAY_BITS : tis_pkg::PERIOD_W;
   localparam int EW = DAY_BITS + 1;

   // entry: {marked, infection day}
   logic [EW-1:0]       mem [NODE_COUNT];
   logic [EW-1:0]       rd_ff;
   logic [EW-1:0]       src_ent_ff;
   logic [AW-1:0]       mem_addr;
   logic [EW-1:0]       mem_wdata;
   logic                mem_we;

   logic [AW-1:0]       clr_cnt_ff;
   logic [DAY_BITS-1:0] day_ff;
   logic [DAY_BITS-1:0] last_day_ff;
   logic [AW-1:0]       dst_addr_ff;
   logic [tis_pkg::NODE_W-1:0] tgt_node_ff;
   logic                src_ok_ff;
   logic                dst_ok_ff;

   logic                rsp_valid_ff;
   logic                rsp_newly_ff;
   logic [tis_pkg::NODE_W-1:0] rsp_node_ff;
   logic                rsp_ooo_ff;

   logic [31:0]         src32, dst32, idx32, day32, idx_day32;
   logic                src_ok, dst_ok, idx_ok;
   logic [AW-1:0]       src_addr, dst_addr, idx_addr;
   logic [DAY_BITS-1:0] day_in, idx_day;

   logic                src_mark, dst_mark, ooo, later, in_win, infect;
   logic [DAY_BITS-1:0] src_t, diff;

   assign src32     = 32'(req_source_node);
   assign dst32     = 32'(req_target_node);
   assign idx32     = 32'(cfg.index_node);
   assign day32     = 32'(req_edge_day);
   assign idx_day32 = 32'(cfg.index_day);

   assign src_ok   = src32 < 32'(NODE_COUNT);
   assign dst_ok   = dst32 < 32'(NODE_COUNT);
   assign idx_ok   = idx32 < 32'(NODE_COUNT);
   assign src_addr = src_ok ? src32[AW-1:0] : '0;
   assign dst_addr = dst_ok ? dst32[AW-1:0] : '0;
   assign idx_addr = idx32[AW-1:0];
   assign day_in   = day32[DAY_BITS-1:0];
   assign idx_day  = idx_day32[DAY_BITS-1:0];

   assign stat.clr_last = (clr_cnt_ff == AW'(NODE_COUNT - 1));

   // window test: t + 1 <= day <= t + period, no wrap
   assign src_mark = src_ent_ff[EW-1];
   assign src_t    = src_ent_ff[DAY_BITS-1:0];
   assign dst_mark = rd_ff[EW-1];
   assign ooo      = day_ff < last_day_ff;
   assign later    = day_ff > src_t;
   assign diff     = day_ff - src_t;
   assign in_win   = CW'(diff) <= CW'(cfg.period);
   assign infect   = !ooo && src_ok_ff && dst_ok_ff && src_mark && !dst_mark
                     && later && in_win;

   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = '0;
      mem_wdata = {cmd.mark_run && idx_ok && (clr_cnt_ff == idx_addr), idx_day};
      if (cmd.clear) begin
         mem_we   = 1'b1;
         mem_addr = clr_cnt_ff;
      end else if (cmd.capture) begin
         mem_addr = src_addr;
      end else if (cmd.fetch) begin
         mem_addr = dst_addr_ff;
      end else if (cmd.eval) begin
         mem_we    = infect;
         mem_addr  = dst_addr_ff;
         mem_wdata = {1'b1, day_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         day_ff      <= day_in;
         dst_addr_ff <= dst_addr;
         tgt_node_ff <= req_target_node;
         src_ok_ff   <= src_ok;
         dst_ok_ff   <= dst_ok;
      end
      if (cmd.fetch) begin
         src_ent_ff <= rd_ff;
      end
      if (cmd.eval) begin
         rsp_newly_ff <= infect;
         rsp_node_ff  <= infect ? tgt_node_ff : '0;
         rsp_ooo_ff   <= ooo;
      end else if (cmd.start_done) begin
         rsp_newly_ff <= 1'b0;
         rsp_node_ff  <= '0;
         rsp_ooo_ff   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         last_day_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.eval || cmd.start_done;
         if (cmd.clear) begin
            clr_cnt_ff <= stat.clr_last ? '0 : clr_cnt_ff + AW'(1);
         end
         if (cmd.start_done) begin
            last_day_ff <= '0;
         end else if (cmd.eval && !ooo) begin
            last_day_ff <= day_ff;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_newly_infected = rsp_newly_ff;
   assign rsp_infected_node  = rsp_node_ff;
   assign rsp_out_of_order   = rsp_ooo_ff;

endmodule

>>> src/temporal_infection_spread_core.sv
// top level of the temporal infection spread core
//
//   channel   handshake             payload
//   request   start / busy          req_func, req_edge_day, req_source_node, req_target_node
//   result    rsp_valid strobe      rsp_newly_infected, rsp_infected_node, rsp_out_of_order
//   config    psel/penable/pready   paddr, pwrite, pwdata, prdata
//
// an edge beat reads the source entry at the accept edge, then reads the target entry,
// then evaluates and writes; the single-port node table sets this sequence
// a start beat sweeps the whole node table before busy drops
// after reset busy stays high for a clearing sweep of the table
// the result strobe is registered and shows in the cycle after the work ends; the receiver cannot stall
`timescale 1ns / 1ps

module temporal_infection_spread_core #(
   parameter int NODE_COUNT = 1024,
   parameter int DAY_BITS   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_func,
   input  logic [tis_pkg::FIELD_DAY_W-1:0]    req_edge_day,
   input  logic [tis_pkg::NODE_W-1:0]         req_source_node,
   input  logic [tis_pkg::NODE_W-1:0]         req_target_node,
   output logic                               rsp_valid,
   output logic                               rsp_newly_infected,
   output logic [tis_pkg::NODE_W-1:0]         rsp_infected_node,
   output logic                               rsp_out_of_order,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tis_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tis_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tis_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   tis_pkg::tis_cfg_type  cfg;
   tis_pkg::tis_cmd_type  cmd;
   tis_pkg::tis_stat_type stat;

   tis_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tis_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   tis_dp #(
      .NODE_COUNT (NODE_COUNT),
      .DAY_BITS   (DAY_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cfg                (cfg),
      .req_edge_day       (req_edge_day),
      .req_source_node    (req_source_node),
      .req_target_node    (req_target_node),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_newly_infected (rsp_newly_infected),
      .rsp_infected_node  (rsp_infected_node),
      .rsp_out_of_order   (rsp_out_of_order)
   );

endmodule

>>> src/tis_check.sv
// port-level checker for the infection spread core, bound to the top level
`timescale 1ns / 1ps
`include "temporal_infection_spread_core_assert.svh"

module tis_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       req_func,
   input logic                       rsp_valid,
   input logic                       rsp_newly_infected,
   input logic [tis_pkg::NODE_W-1:0] rsp_infected_node,
   input logic                       rsp_out_of_order
);

   `TIS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
   `TIS_ASSERT_SAME(a_edge_result_latency, start && !busy && !req_func, ##3 rsp_valid)
   `TIS_ASSERT_NEXT(a_single_beat, rsp_valid, !rsp_valid)
   `TIS_ASSERT_SAME(a_flags_exclusive, rsp_valid, !(rsp_newly_infected && rsp_out_of_order))
   `TIS_ASSERT_SAME(a_node_zero_when_none, rsp_valid && !rsp_newly_infected,
                    rsp_infected_node == '0)

endmodule

bind temporal_infection_spread_core tis_check u_tis_check (.*);

>>> verif/temporal_infection_spread_core_tb.sv
// self-checking testbench for the temporal infection spread core
`timescale 1ns / 1ps

module temporal_infection_spread_core_tb;

   localparam int NODE_COUNT   = 1024;
   localparam int DAY_MAX      = 65535;
   localparam int RANDOM_ITEMS = 1530;
   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT  = 4000000;

   localparam logic FUNC_EDGE  = 1'b0;
   localparam logic FUNC_START = 1'b1;

   typedef struct packed {
      logic                            func;
      logic [tis_pkg::FIELD_DAY_W-1:0] day;
      logic [tis_pkg::NODE_W-1:0]      src;
      logic [tis_pkg::NODE_W-1:0]      dst;
   } contact_beat_type;

   typedef struct packed {
      logic                       newly;
      logic [tis_pkg::NODE_W-1:0] node;
      logic                       ooo;
   } spread_out_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic [1:0]       reg_idx;
      logic [31:0]      reg_value;
      contact_beat_type beat;
      logic             fixed;
      spread_out_type   want;
   } plan_row_type;

   localparam spread_out_type NO_SPREAD  = '{1'b0, 10'd0, 1'b0};
   localparam spread_out_type LATE_EDGE  = '{1'b0, 10'd0, 1'b1};

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic                            req_func;
   logic [tis_pkg::FIELD_DAY_W-1:0] req_edge_day;
   logic [tis_pkg::NODE_W-1:0]      req_source_node;
   logic [tis_pkg::NODE_W-1:0]      req_target_node;
   logic                            rsp_valid;
   logic                            rsp_newly_infected;
   logic [tis_pkg::NODE_W-1:0]      rsp_infected_node;
   logic                            rsp_out_of_order;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [tis_pkg::CSR_ADDR_W-1:0]  paddr;
   logic [tis_pkg::CSR_DATA_W-1:0]  pwdata;
   logic [tis_pkg::CSR_DATA_W-1:0]  prdata;
   logic                            pready;

   temporal_infection_spread_core #(
      .NODE_COUNT (NODE_COUNT),
      .DAY_BITS   (16)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_edge_day       (req_edge_day),
      .req_source_node    (req_source_node),
      .req_target_node    (req_target_node),
      .rsp_valid          (rsp_valid),
      .rsp_newly_infected (rsp_newly_infected),
      .rsp_infected_node  (rsp_infected_node),
      .rsp_out_of_order   (rsp_out_of_order),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // shadow configuration and node table
   logic [tis_pkg::NODE_W-1:0]      cfg_index_node;
   logic [tis_pkg::FIELD_DAY_W-1:0] cfg_index_day;
   logic [tis_pkg::PERIOD_W-1:0]    cfg_period;
   bit                              node_marked [NODE_COUNT];
   logic [tis_pkg::FIELD_DAY_W-1:0] node_day    [NODE_COUNT];
   logic [tis_pkg::FIELD_DAY_W-1:0] last_day;
   int                              marked_q[$];

   spread_out_type pending_spread_q[$];
   int             error_count;
   int             cycle_count;
   int             burst_left;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void spread_step(input contact_beat_type b, output spread_out_type o);
      int unsigned t;
      o = NO_SPREAD;
      if (b.func == FUNC_START) begin
         foreach (node_marked[n]) node_marked[n] = 1'b0;
         marked_q.delete();
         last_day = '0;
         if (int'(cfg_index_node) < NODE_COUNT) begin
            node_marked[cfg_index_node] = 1'b1;
            node_day[cfg_index_node]    = cfg_index_day;
            marked_q.push_back(int'(cfg_index_node));
         end
      end else if (b.day < last_day) begin
         o.ooo = 1'b1;
      end else begin
         last_day = b.day;
         if (int'(b.src) < NODE_COUNT && int'(b.dst) < NODE_COUNT &&
             node_marked[b.src] && !node_marked[b.dst]) begin
            t = node_day[b.src];
            // exact window, no wrap: t + 1 <= day <= t + k
            if (b.day >= t + 1 && int'(b.day) - t <= cfg_period) begin
               node_marked[b.dst] = 1'b1;
               node_day[b.dst]    = b.day;
               marked_q.push_back(int'(b.dst));
               o.newly = 1'b1;
               o.node  = b.dst;
            end
         end
      end
   endfunction

   function automatic plan_row_type beat_row(input logic func, input int day, input int src,
                                             input int dst, input logic fixed,
                                             input spread_out_type want);
      plan_row_type r;
      r.kind      = ROW_BEAT;
      r.reg_idx   = tis_pkg::REG_INDEX_NODE;
      r.reg_value = '0;
      r.beat      = '{func, 16'(day), 10'(src), 10'(dst)};
      r.fixed     = fixed;
      r.want      = want;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [1:0] idx, input logic [31:0] value);
      plan_row_type r;
      r.kind      = ROW_CSR;
      r.reg_idx   = idx;
      r.reg_value = value;
      r.beat      = '0;
      r.fixed     = 1'b0;
      r.want      = NO_SPREAD;
      return r;
   endfunction

   // holds start with the beat until accepted; returns at the accepting edge
   task automatic send_beat(input contact_beat_type b, input logic fixed,
                            input spread_out_type want);
      spread_out_type predicted;
      start           <= 1'b1;
      req_func        <= b.func;
      req_edge_day    <= b.day;
      req_source_node <= b.src;
      req_target_node <= b.dst;
      @(posedge clock);
      while (busy) @(posedge clock);
      spread_step(b, predicted);
      pending_spread_q.push_back(fixed ? want : predicted);
   endtask

   task automatic pause_sender(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         pause_sender($urandom_range(1, 9));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic wait_idle();
      pause_sender(1);
      while (pending_spread_q.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         tis_pkg::REG_INDEX_NODE: cfg_index_node = value[tis_pkg::NODE_W-1:0];
         tis_pkg::REG_INDEX_DAY:  cfg_index_day  = value[tis_pkg::FIELD_DAY_W-1:0];
         tis_pkg::REG_PERIOD:     cfg_period     = value[tis_pkg::PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   // result beats, one per accepted beat, in order
   always @(posedge clock) begin : result_check
      spread_out_type want;
      if (!reset && rsp_valid) begin
         if (pending_spread_q.size() == 0) begin
            $error("result beat with nothing pending: node %0d", rsp_infected_node);
            error_count++;
         end else begin
            want = pending_spread_q.pop_front();
            if (rsp_newly_infected !== want.newly) begin
               $error("newly_infected expected %0d got %0d", want.newly, rsp_newly_infected);
               error_count++;
            end
            if (rsp_infected_node !== want.node) begin
               $error("infected_node expected %0d got %0d", want.node, rsp_infected_node);
               error_count++;
            end
            if (rsp_out_of_order !== want.ooo) begin
               $error("out_of_order expected %0d got %0d", want.ooo, rsp_out_of_order);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[temporal_infection_spread_core] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type     plan[$];
      contact_beat_type b;
      int               random_left;
      int               run_len;
      int               pick;
      int               base;
      int               span;

      error_count     = 0;
      cycle_count     = 0;
      burst_left      = 0;
      cfg_index_node  = '0;
      cfg_index_day   = '0;
      cfg_period      = 16'd1;
      last_day        = '0;
      foreach (node_marked[n]) begin
         node_marked[n] = 1'b0;
         node_day[n]    = '0;
      end
      reset           = 1'b1;
      start           = 1'b0;
      req_func        = FUNC_EDGE;
      req_edge_day    = '0;
      req_source_node = '0;
      req_target_node = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;

      // nothing marked before the first start
      plan.push_back(beat_row(FUNC_EDGE, 0, 0, 5, 1'b1, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, DAY_MAX, 1023, 1023, 1'b1, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 0, 0, 1, 1'b1, LATE_EDGE));
      plan.push_back(beat_row(FUNC_START, 0, 0, 0, 1'b1, NO_SPREAD));
      // index node on day 0, period 1
      plan.push_back(beat_row(FUNC_EDGE, 0, 0, 1, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 1, 0, 1023, 1'b1, '{1'b1, 10'd1023, 1'b0}));
      plan.push_back(beat_row(FUNC_EDGE, 1, 1023, 2, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 2, 1023, 0, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 2, 0, 3, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 2, 1023, 2, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 2, 5, 6, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 1, 2, 7, 1'b1, LATE_EDGE));
      plan.push_back(beat_row(FUNC_EDGE, 3, 2, 2, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 3, 2, 682, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 4, 682, 341, 1'b0, NO_SPREAD));
      // a new run forgets everything
      plan.push_back(beat_row(FUNC_START, 0, 0, 0, 1'b1, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 1, 1023, 4, 1'b0, NO_SPREAD));
      // widest window reaches the top day
      plan.push_back(csr_row(tis_pkg::REG_INDEX_NODE, 32'hFFFF_FFFF));
      plan.push_back(csr_row(tis_pkg::REG_INDEX_DAY, 32'hABCD_0000));
      plan.push_back(csr_row(tis_pkg::REG_PERIOD, 32'h0000_FFFF));
      plan.push_back(beat_row(FUNC_START, 0, 0, 0, 1'b1, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, DAY_MAX, 1023, 0, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, DAY_MAX, 0, 1, 1'b0, NO_SPREAD));
      // infected on the top day, no later day exists
      plan.push_back(csr_row(tis_pkg::REG_INDEX_DAY, 32'h0000_FFFF));
      plan.push_back(csr_row(tis_pkg::REG_PERIOD, 32'h0000_0001));
      plan.push_back(beat_row(FUNC_START, 0, 0, 0, 1'b1, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, DAY_MAX, 1023, 5, 1'b0, NO_SPREAD));
      plan.push_back(beat_row(FUNC_EDGE, 0, 1023, 6, 1'b1, LATE_EDGE));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(plan[i].reg_idx, plan[i].reg_value);
         end else begin
            send_beat(plan[i].beat, plan[i].fixed, plan[i].want);
            pace_sender();
         end
      end

      random_left = RANDOM_ITEMS;
      while (random_left > 0) begin
         if ($urandom_range(0, 9) < 6) begin
            wait_idle();
            pick = $urandom_range(0, 99);
            csr_write(tis_pkg::REG_INDEX_NODE, {22'($urandom),
                      pick < 15 ? 10'd0 : pick < 30 ? 10'd1023 : 10'($urandom)});
            pick = $urandom_range(0, 99);
            csr_write(tis_pkg::REG_INDEX_DAY, {16'($urandom),
                      pick < 10 ? 16'd0 : pick < 20 ? 16'hFFFF :
                      pick < 30 ? 16'($urandom_range(65500, DAY_MAX)) : 16'($urandom)});
            pick = $urandom_range(0, 99);
            csr_write(tis_pkg::REG_PERIOD, {16'($urandom),
                      pick < 15 ? 16'd1 : pick < 25 ? 16'hFFFF :
                      pick < 75 ? 16'($urandom_range(1, 4)) : 16'($urandom_range(1, DAY_MAX))});
         end
         send_beat('{FUNC_START, 16'($urandom), 10'($urandom), 10'($urandom)}, 1'b0, NO_SPREAD);
         random_left--;
         pace_sender();

         run_len = $urandom_range(10, 70);
         for (int i = 0; i < run_len && random_left > 0; i++) begin
            pick    = $urandom_range(0, 99);
            b.func  = FUNC_EDGE;
            b.src   = 10'($urandom);
            b.dst   = 10'($urandom);
            b.day   = 16'($urandom);
            if (pick < 2) begin
               b.func = FUNC_START;
            end else if (pick < 8 && last_day != 0) begin
               b.day = 16'($urandom_range(0, int'(last_day) - 1));
            end else if (pick >= 14) begin
               // well-formed contact: day moves forward slowly, sources mostly infected
               base = (last_day < cfg_index_day) ? int'(cfg_index_day) : int'(last_day);
               pick = $urandom_range(0, 99);
               span = pick < 45 ? 0 : pick < 80 ? 1 : pick < 95 ? $urandom_range(2, 4)
                                                 : $urandom_range(0, int'(cfg_period) + 1);
               b.day = (base + span > DAY_MAX) ? 16'hFFFF : 16'(base + span);
               pick = $urandom_range(0, 99);
               if (marked_q.size() > 0 && pick < 50)
                  b.src = 10'(marked_q[$urandom_range(marked_q.size() > 4 ?
                                                      marked_q.size() - 4 : 0,
                                                      marked_q.size() - 1)]);
               else if (marked_q.size() > 0 && pick < 75)
                  b.src = 10'(marked_q[$urandom_range(0, marked_q.size() - 1)]);
               else
                  b.src = cfg_index_node + 10'($urandom_range(0, 47));
               if ($urandom_range(0, 99) < 80)
                  b.dst = cfg_index_node + 10'($urandom_range(0, 47));
            end
            send_beat(b, 1'b0, NO_SPREAD);
            random_left--;
            pace_sender();
         end
      end

      pause_sender(1);
      while (pending_spread_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[temporal_infection_spread_core] OK");
      else
         $display("[temporal_infection_spread_core] ERROR");
      $finish;
   end

endmodule
